[design/lmfc_pkg.sv]
// Package for the detail-level crossfade controller.
// Holds fixed-point formats, register indexes, and controller/datapath command types.
// No dependencies.
package lmfc_pkg;

    // Level and phase formats
    localparam int LEVEL_BITS      = 5;
    localparam int PHASE_FRAC_BITS = 16;
    localparam int PHASE_W         = PHASE_FRAC_BITS + 1;
    localparam logic [PHASE_W-1:0] PHASE_ONE  = {1'b1, {PHASE_FRAC_BITS{1'b0}}};
    localparam logic [PHASE_W-1:0] PHASE_HALF = PHASE_ONE >> 1;

    // Fixed field widths
    localparam int SPEED_W = 16;
    localparam int DT_W    = 16;
    localparam int CD_W    = 16;
    localparam int BIAS_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // speed (Q8.8) * dt (Q0.16) is Q8.24, scaled down to the phase format
    localparam int INC_W       = SPEED_W + DT_W;
    localparam int SPEED_SHIFT = 24 - PHASE_FRAC_BITS;
    localparam logic [SPEED_W-1:0] SPEED_DEFAULT = 16'd768;

    // Shared signed multiplier operand widths
    localparam int MA_W = (PHASE_FRAC_BITS + 2 > SPEED_W + 1) ? PHASE_FRAC_BITS + 2 : SPEED_W + 1;
    localparam int MB_W = (PHASE_FRAC_BITS + 3 > DT_W + 1) ? PHASE_FRAC_BITS + 3 : DT_W + 1;
    localparam int MP_W = MA_W + MB_W;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LEVEL = 1'b0,
        CFG_FADE_SPEED  = 1'b1
    } t_cfg_idx;

    // Command codes
    typedef enum logic {
        CMD_TICK     = 1'b0,
        CMD_RETARGET = 1'b1
    } t_cmd;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture input beat
        logic mul_inc;  // speed * dt
        logic upd;      // apply command to state
        logic mul_sq;   // t * t
        logic mul_cube; // t2 * (3 - 2t)
        logic wgt;      // round and clamp weight
        logic mul_bias; // cell gap * (1 - w)
        logic done;     // load output register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

[design/lmfc_ctrl.sv]
// Sequencing state machine for the crossfade controller.
// Depends on lmfc_pkg; drives lmfc_dp through t_dp_cmd.
module lmfc_ctrl import lmfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_INC  = 8'b0000_0010,
        S_UPD  = 8'b0000_0100,
        S_SQ   = 8'b0000_1000,
        S_CUBE = 8'b0001_0000,
        S_WGT  = 8'b0010_0000,
        S_BIAS = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    // Step through the fixed schedule; wait in S_DONE for a free output slot
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_INC;
                end
            end
            S_INC: begin
                o_cmd.mul_inc = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_SQ;
            end
            S_SQ: begin
                o_cmd.mul_sq = 1'b1;
                n_state      = S_CUBE;
            end
            S_CUBE: begin
                o_cmd.mul_cube = 1'b1;
                n_state        = S_WGT;
            end
            S_WGT: begin
                o_cmd.wgt = 1'b1;
                n_state   = S_BIAS;
            end
            S_BIAS: begin
                o_cmd.mul_bias = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/lmfc_dp.sv]
// Datapath for the crossfade controller: fade state, one shared multiplier, output register.
// Depends on lmfc_pkg; sequenced by lmfc_ctrl.
module lmfc_dp import lmfc_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_sts                      o_sts,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    // input beat
    input  logic                         i_cmd_code,
    input  logic [LEVEL_BITS-1:0]        i_new_level,
    input  logic [DT_W-1:0]              i_dt,
    input  logic signed [CD_W-1:0]       i_cell_gap,
    // output beat
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_active,
    output logic [PHASE_W-1:0]           o_weight,
    output logic signed [BIAS_W-1:0]     o_y_bias,
    output logic [LEVEL_BITS-1:0]        o_from_level,
    output logic [LEVEL_BITS-1:0]        o_to_level
);

    // Captured input beat
    logic                     r_cmd;
    logic [LEVEL_BITS-1:0]    r_lvl;
    logic [DT_W-1:0]          r_dt;
    logic signed [CD_W-1:0]   r_cd;

    // Fade state and configuration
    logic [SPEED_W-1:0]       r_speed;
    logic [LEVEL_BITS-1:0]    r_src, r_tgt;
    logic [PHASE_W-1:0]       r_phase;
    logic                     r_fading;

    // Working registers
    logic signed [MP_W-1:0]   r_prod;
    logic [PHASE_W-1:0]       r_w;
    logic                     r_bias_en;

    // Output register
    logic                     r_out_valid;
    logic                     r_o_active;
    logic [PHASE_W-1:0]       r_o_weight;
    logic signed [BIAS_W-1:0] r_o_bias;
    logic [LEVEL_BITS-1:0]    r_o_from, r_o_to;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [MP_W-1:0]   n_prod;
    logic [SPEED_W-1:0]       speed_eff;
    logic [PHASE_W:0]         two_t;
    logic [PHASE_W:0]         three_minus;
    logic [MP_W-1:0]          prod_u;
    logic [MP_W-1:0]          round_sum;
    logic [PHASE_W-1:0]       t2;
    logic [MP_W-PHASE_FRAC_BITS-1:0] w_raw;
    logic [PHASE_W-1:0]       w_clamp;
    logic [PHASE_W-1:0]       one_minus_w;
    logic [INC_W-1:0]         inc;
    logic [INC_W:0]           phase_sum;
    logic                     bias_neg;
    logic [MP_W-1:0]          bias_mag;
    logic [MP_W-1:0]          bias_rnd;
    logic [BIAS_W-1:0]        bias_r;
    logic signed [BIAS_W-1:0] bias_val;

    assign speed_eff   = (r_speed == '0) ? SPEED_DEFAULT : r_speed;
    assign two_t       = {r_phase, 1'b0};
    assign three_minus = (PHASE_W + 1)'(3 * (2 ** PHASE_FRAC_BITS)) - two_t;
    assign prod_u      = $unsigned(r_prod);
    assign round_sum   = prod_u + MP_W'(PHASE_HALF);
    assign t2          = round_sum[2*PHASE_FRAC_BITS:PHASE_FRAC_BITS];
    assign w_raw       = round_sum[MP_W-1:PHASE_FRAC_BITS];
    assign w_clamp     = (w_raw > (MP_W - PHASE_FRAC_BITS)'(PHASE_ONE)) ? PHASE_ONE
                                                                      : w_raw[PHASE_W-1:0];
    assign one_minus_w = PHASE_ONE - r_w;

    // Select the operands of the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (i_cmd.mul_inc) begin
            mul_a = MA_W'(speed_eff);
            mul_b = MB_W'(r_dt);
        end else if (i_cmd.mul_sq) begin
            mul_a = MA_W'(r_phase);
            mul_b = MB_W'(r_phase);
        end else if (i_cmd.mul_cube) begin
            mul_a = MA_W'(t2);
            mul_b = MB_W'(three_minus);
        end else if (i_cmd.mul_bias) begin
            mul_a = MA_W'(r_cd);
            mul_b = MB_W'(one_minus_w);
        end
    end

    assign n_prod = mul_a * mul_b;

    // Phase advance for a tick
    assign inc       = prod_u[INC_W-1:0] >> SPEED_SHIFT;
    assign phase_sum = (INC_W + 1)'(r_phase) + (INC_W + 1)'(inc);

    // Bias: round magnitude half away from zero, then point downward
    assign bias_neg = r_prod[MP_W-1];
    assign bias_mag = bias_neg ? $unsigned(-r_prod) : prod_u;
    assign bias_rnd = (bias_mag + MP_W'(PHASE_ONE)) >> (PHASE_FRAC_BITS + 1);
    assign bias_r   = bias_rnd[BIAS_W-1:0];
    assign bias_val = bias_neg ? $signed(bias_r) : -$signed(bias_r);

    // Capture the input beat and working values
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_cmd_code;
            r_lvl <= i_new_level;
            r_dt  <= i_dt;
            r_cd  <= i_cell_gap;
        end
        if (i_cmd.mul_inc || i_cmd.mul_sq || i_cmd.mul_cube || i_cmd.mul_bias) begin
            r_prod <= n_prod;
        end
        if (i_cmd.wgt) begin
            r_w       <= r_fading ? w_clamp : PHASE_ONE;
            r_bias_en <= r_fading && (r_tgt > r_src);
        end
        if (i_cmd.done) begin
            r_o_active <= r_fading;
            r_o_weight <= r_w;
            r_o_bias   <= r_bias_en ? bias_val : '0;
            r_o_from   <= r_src;
            r_o_to     <= r_tgt;
        end
    end

    // Fade state: configuration writes and command updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= SPEED_DEFAULT;
            r_src    <= '0;
            r_tgt    <= '0;
            r_phase  <= PHASE_ONE;
            r_fading <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START_LEVEL: begin
                    r_src    <= i_cfg_data[LEVEL_BITS-1:0];
                    r_tgt    <= i_cfg_data[LEVEL_BITS-1:0];
                    r_phase  <= PHASE_ONE;
                    r_fading <= 1'b0;
                end
                CFG_FADE_SPEED: begin
                    r_speed <= i_cfg_data[SPEED_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_cmd.upd) begin
            if (t_cmd'(r_cmd) == CMD_RETARGET) begin
                if (r_lvl != r_tgt) begin
                    if (!r_fading || (r_phase >= PHASE_HALF)) begin
                        r_src <= r_tgt;
                    end
                    r_tgt    <= r_lvl;
                    r_phase  <= '0;
                    r_fading <= 1'b1;
                end
            end else if (r_fading) begin
                if (phase_sum >= (INC_W + 1)'(PHASE_ONE)) begin
                    r_phase  <= PHASE_ONE;
                    r_src    <= r_tgt;
                    r_fading <= 1'b0;
                end else begin
                    r_phase <= phase_sum[PHASE_W-1:0];
                end
            end
        end
    end

    // Output valid: set on done, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_active     = r_o_active;
    assign o_weight     = r_o_weight;
    assign o_y_bias     = r_o_bias;
    assign o_from_level = r_o_from;
    assign o_to_level   = r_o_to;

endmodule

[design/lod_morph_fade_controller_unit.sv]
// Detail-level crossfade controller: one result beat for every command beat, and no
// new command beat until the last is done, because one shared multiplier forms speed*dt, t*t,
// t2*(3-2t) and cell_gap*(1-w) in turn under a fixed controller schedule. A
// finished result waits in the output register, so the next command is taken while
// it is still stalled; only a second finished result waits for that slot. The
// configuration port is always ready and is to be written only while idle.
// Top level; depends on lmfc_pkg, lmfc_ctrl and lmfc_dp.
module lod_morph_fade_controller_unit import lmfc_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    // command channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_cmd,
    input  logic [LEVEL_BITS-1:0]     i_new_level,
    input  logic [DT_W-1:0]           i_dt,
    input  logic signed [CD_W-1:0]    i_cell_gap,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_active,
    output logic [PHASE_W-1:0]        o_weight,
    output logic signed [BIAS_W-1:0]  o_y_bias,
    output logic [LEVEL_BITS-1:0]     o_from_level,
    output logic [LEVEL_BITS-1:0]     o_to_level
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    lmfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    lmfc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_code   (i_cmd),
        .i_new_level  (i_new_level),
        .i_dt         (i_dt),
        .i_cell_gap   (i_cell_gap),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_active     (o_active),
        .o_weight     (o_weight),
        .o_y_bias     (o_y_bias),
        .o_from_level (o_from_level),
        .o_to_level   (o_to_level)
    );

    // An accepted beat closes the input until its result is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken twice in a row");

    // Weight never exceeds one
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_weight <= PHASE_ONE))
        else $error("weight above one");

    // A settled result carries full weight and no bias
    a_settled_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_active) |-> ((o_weight == PHASE_ONE) && (o_y_bias == '0)))
        else $error("settled result with partial weight or bias");

    // Bias only while coarsening
    a_bias_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_to_level <= o_from_level)) |-> (o_y_bias == '0))
        else $error("bias while not coarsening");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the detail-level crossfade controller.
// Drives command beats and register writes, predicts each result beat and scores it in order.
// Depends on lmfc_pkg and lod_morph_fade_controller_unit.
module tb_top import lmfc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int RAND_ITEMS   = 300;      // per idling phase
    localparam longint unsigned ONE_L  = 64'd1 << PHASE_FRAC_BITS;
    localparam longint unsigned HALF_L = ONE_L >> 1;

    typedef struct {
        logic                     active;
        logic [PHASE_W-1:0]       weight;
        logic signed [BIAS_W-1:0] y_bias;
        logic [LEVEL_BITS-1:0]    from_lvl;
        logic [LEVEL_BITS-1:0]    to_lvl;
    } t_fade_out;

    typedef struct {
        bit        known;
        t_fade_out want;
    } t_preset;

    typedef enum {ROW_REG, ROW_BEAT} t_row_kind;

    typedef struct {
        t_row_kind                kind;
        t_cfg_idx                 idx;
        logic [CFG_DATA_W-1:0]    data;
        t_cmd                     cmd;
        logic [LEVEL_BITS-1:0]    lvl;
        logic [DT_W-1:0]          dt;
        logic signed [CD_W-1:0]   cd;
        bit                       known;
        t_fade_out                want;
    } t_row;

    // DUT ports
    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_cmd;
    logic [LEVEL_BITS-1:0]    i_new_level;
    logic [DT_W-1:0]          i_dt;
    logic signed [CD_W-1:0]   i_cell_gap;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic                     o_active;
    logic [PHASE_W-1:0]       o_weight;
    logic signed [BIAS_W-1:0] o_y_bias;
    logic [LEVEL_BITS-1:0]    o_from_level;
    logic [LEVEL_BITS-1:0]    o_to_level;

    // Predicted controller state
    logic [LEVEL_BITS-1:0]    fd_source = '0;
    logic [LEVEL_BITS-1:0]    fd_target = '0;
    logic [PHASE_W-1:0]       fd_phase  = PHASE_ONE;
    logic                     fd_fading = 1'b0;
    logic [SPEED_W-1:0]       fd_speed  = SPEED_DEFAULT;

    t_fade_out                pending_fades[$];
    t_preset                  preset_q[$];
    t_row                     dir_rows[$];

    int                       send_idle_pct = 0;
    int                       recv_stall_pct = 0;
    logic [LEVEL_BITS-1:0]    drv_target = '0;
    int                       n_mismatch = 0;
    int                       n_checked = 0;
    int                       n_ticks = 0;
    int                       n_retargets = 0;
    int                       n_reg_writes = 0;
    int                       cycles = 0;

    lod_morph_fade_controller_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_new_level  (i_new_level),
        .i_dt         (i_dt),
        .i_cell_gap   (i_cell_gap),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_active     (o_active),
        .o_weight     (o_weight),
        .o_y_bias     (o_y_bias),
        .o_from_level (o_from_level),
        .o_to_level   (o_to_level)
    );

    always #4 i_clk = ~i_clk;

    // Smoothstep of a Q1.16 phase, halves rounded up, clamped at 1.0
    function automatic logic [PHASE_W-1:0] smooth_q16(input logic [PHASE_W-1:0] t);
        longint unsigned tl;
        longint unsigned t2;
        longint unsigned w;
        tl = 64'(t);
        if (tl >= ONE_L) return PHASE_ONE;
        t2 = (tl * tl + HALF_L) >> PHASE_FRAC_BITS;
        w  = (t2 * (3 * ONE_L - 2 * tl) + HALF_L) >> PHASE_FRAC_BITS;
        if (w > ONE_L) return PHASE_ONE;
        return w[PHASE_W-1:0];
    endfunction

    // Apply one command beat to the predicted state and return its result beat
    function automatic t_fade_out fade_step(input t_cmd cmd, input logic [LEVEL_BITS-1:0] lvl,
                                            input logic [DT_W-1:0] dt,
                                            input logic signed [CD_W-1:0] cd);
        t_fade_out       r;
        longint unsigned spd;
        longint unsigned inc;
        longint unsigned mag;
        longint unsigned rnd;
        longint          prod;
        longint          bias;
        logic [PHASE_W-1:0] w;
        if (cmd == CMD_RETARGET) begin
            if (lvl != fd_target) begin
                // source is whichever end the phase is nearer
                if (!fd_fading || fd_phase >= PHASE_HALF) fd_source = fd_target;
                fd_target = lvl;
                fd_phase  = '0;
                fd_fading = 1'b1;
            end
        end else if (fd_fading) begin
            spd = (fd_speed == '0) ? 64'(SPEED_DEFAULT) : 64'(fd_speed);
            inc = (spd * 64'(dt)) >> (24 - PHASE_FRAC_BITS);
            if (64'(fd_phase) + inc >= ONE_L) begin
                fd_phase  = PHASE_ONE;
                fd_source = fd_target;
                fd_fading = 1'b0;
            end else begin
                fd_phase = fd_phase + inc[PHASE_W-1:0];
            end
        end
        w = fd_fading ? smooth_q16(fd_phase) : PHASE_ONE;
        bias = 0;
        // coarsening only: half of the cell gap times (1 - w), magnitude rounded half away
        if (fd_fading && fd_target > fd_source) begin
            prod = longint'(cd) * longint'(ONE_L - 64'(w));
            mag  = (prod < 0) ? 64'(-prod) : 64'(prod);
            rnd  = (mag + ONE_L) >> (PHASE_FRAC_BITS + 1);
            bias = (prod < 0) ? longint'(rnd) : -longint'(rnd);
        end
        r.active   = fd_fading;
        r.weight   = w;
        r.y_bias   = bias[BIAS_W-1:0];
        r.from_lvl = fd_source;
        r.to_lvl   = fd_target;
        return r;
    endfunction

    function automatic void report_fade(input string tag, input t_fade_out f);
        $display("  %s act=%0d w=%0d bias=%0d from=%0d to=%0d",
                 tag, f.active, f.weight, f.y_bias, f.from_lvl, f.to_lvl);
    endfunction

    // Score one result beat against the oldest prediction
    function automatic void score_fade(input t_fade_out got);
        t_fade_out want;
        if (pending_fades.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS) begin
                $display("mismatch: result beat with nothing expected at cycle %0d", cycles);
                report_fade("got     ", got);
            end
            return;
        end
        want = pending_fades.pop_front();
        n_checked++;
        if (got.active !== want.active || got.weight !== want.weight ||
            got.y_bias !== want.y_bias || got.from_lvl !== want.from_lvl ||
            got.to_lvl !== want.to_lvl) begin
            n_mismatch++;
            if (n_mismatch <= MAX_REPORTS) begin
                $display("mismatch: result beat %0d at cycle %0d", n_checked, cycles);
                report_fade("expected", want);
                report_fade("got     ", got);
            end
        end
    endfunction

    // Monitor: outputs first, since a beat accepted now cannot have its result yet
    always @(posedge i_clk) begin : monitor
        t_fade_out got;
        t_fade_out pred;
        t_preset   pre;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got.active   = o_active;
                got.weight   = o_weight;
                got.y_bias   = o_y_bias;
                got.from_lvl = o_from_level;
                got.to_lvl   = o_to_level;
                score_fade(got);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_START_LEVEL: begin
                        fd_source = i_cfg_data[LEVEL_BITS-1:0];
                        fd_target = i_cfg_data[LEVEL_BITS-1:0];
                        fd_phase  = PHASE_ONE;
                        fd_fading = 1'b0;
                    end
                    CFG_FADE_SPEED: begin
                        fd_speed = i_cfg_data[SPEED_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                pred = fade_step(t_cmd'(i_cmd), i_new_level, i_dt, i_cell_gap);
                pre  = preset_q.pop_front();
                pending_fades.push_back(pre.known ? pre.want : pred);
            end
        end
    end

    // Hold the run to a bounded number of cycles
    always @(posedge i_clk) begin
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_fades.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver stalls at random
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Send one command beat after a random idle gap, wait until it is taken
    task automatic send_beat(input t_cmd cmd, input logic [LEVEL_BITS-1:0] lvl,
                             input logic [DT_W-1:0] dt, input logic signed [CD_W-1:0] cd,
                             input bit known, input t_fade_out want);
        int      gap;
        t_preset pre;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pre.known = known;
        pre.want  = want;
        preset_q.push_back(pre);
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_new_level <= lvl;
        i_dt        <= dt;
        i_cell_gap  <= cd;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == CMD_RETARGET) begin
            drv_target = lvl;
            n_retargets++;
        end else begin
            n_ticks++;
        end
    endtask

    // Stop sending and wait until every predicted result has come out
    task automatic drain_fades();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_fades.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_START_LEVEL) drv_target = data[LEVEL_BITS-1:0];
        n_reg_writes++;
    endtask

    // Empty table row of the given kind
    function automatic t_row blank_row(input t_row_kind kind);
        t_row r;
        r.kind  = kind;
        r.idx   = CFG_START_LEVEL;
        r.data  = '0;
        r.cmd   = CMD_TICK;
        r.lvl   = '0;
        r.dt    = '0;
        r.cd    = '0;
        r.known = 1'b0;
        r.want  = '{default: '0};
        return r;
    endfunction

    // Directed table builders
    task automatic add_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r = blank_row(ROW_REG);
        r.idx  = idx;
        r.data = data;
        dir_rows.push_back(r);
    endtask

    task automatic add_beat(input t_cmd cmd, input logic [LEVEL_BITS-1:0] lvl,
                            input logic [DT_W-1:0] dt, input logic signed [CD_W-1:0] cd);
        t_row r;
        r = blank_row(ROW_BEAT);
        r.cmd  = cmd;
        r.lvl  = lvl;
        r.dt   = dt;
        r.cd   = cd;
        dir_rows.push_back(r);
    endtask

    task automatic add_known(input t_cmd cmd, input logic [LEVEL_BITS-1:0] lvl,
                             input logic [DT_W-1:0] dt, input logic signed [CD_W-1:0] cd,
                             input logic act, input logic [PHASE_W-1:0] w,
                             input logic signed [BIAS_W-1:0] bias,
                             input logic [LEVEL_BITS-1:0] from_lvl,
                             input logic [LEVEL_BITS-1:0] to_lvl);
        add_beat(cmd, lvl, dt, cd);
        dir_rows[$].known = 1'b1;
        dir_rows[$].want  = '{act, w, bias, from_lvl, to_lvl};
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_speed();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 16'hFFFF;
            2:       return 16'd1;
            3:       return SPEED_DEFAULT;
            4:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(64, 2048));
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(9))
            5, 6:    return 16'($urandom_range(0, 65535));
            7:       return 16'($urandom_range(0, 255));
            8:       return 16'hFFFF;
            9:       return '0;
            default: return 16'($urandom_range(0, 6000));
        endcase
    endfunction

    function automatic logic [LEVEL_BITS-1:0] pick_level();
        case ($urandom_range(9))
            0, 1:    return drv_target;
            2, 3:    return drv_target + 1'b1;
            4:       return drv_target - 1'b1;
            default: return LEVEL_BITS'($urandom_range(0, (1 << LEVEL_BITS) - 1));
        endcase
    endfunction

    function automatic logic signed [CD_W-1:0] pick_cd();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin : stimulus
        t_fade_out none;
        t_cmd      cmd;
        none = '{default: '0};
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_START_LEVEL;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_cmd       <= CMD_TICK;
        i_new_level <= '0;
        i_dt        <= '0;
        i_cell_gap  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: reset state, same-target retarget, bias extremes, settle,
        // both sides of the half-phase rule, default and extreme speeds, zero increment
        add_known(CMD_TICK,     5'd0,  16'h0000, 16'sh0000, 1'b0, PHASE_ONE, 16'sd0, 5'd0, 5'd0);
        add_known(CMD_RETARGET, 5'd0,  16'h0000, 16'sh7FFF, 1'b0, PHASE_ONE, 16'sd0, 5'd0, 5'd0);
        add_known(CMD_RETARGET, 5'd31, 16'h0000, 16'sh7FFF, 1'b1, '0, -16'sd16384, 5'd0, 5'd31);
        add_known(CMD_TICK,     5'd0,  16'h0000, 16'sh8000, 1'b1, '0, 16'sd16384, 5'd0, 5'd31);
        add_known(CMD_TICK,     5'd0,  16'h8000, 16'sh0100, 1'b0, PHASE_ONE, 16'sd0, 5'd31, 5'd31);
        add_known(CMD_RETARGET, 5'd31, 16'h0000, 16'sh0100, 1'b0, PHASE_ONE, 16'sd0, 5'd31, 5'd31);
        add_known(CMD_RETARGET, 5'd0,  16'h0000, 16'sh0100, 1'b1, '0, 16'sd0, 5'd31, 5'd0);
        add_beat (CMD_TICK,     5'd0,  16'h2AAB, 16'sh0100);
        add_known(CMD_RETARGET, 5'd10, 16'h0000, 16'sh0100, 1'b1, '0, -16'sd128, 5'd0, 5'd10);
        add_beat (CMD_TICK,     5'd0,  16'h2AAA, 16'shFF00);
        add_known(CMD_RETARGET, 5'd20, 16'h0000, 16'sh0000, 1'b1, '0, 16'sd0, 5'd0, 5'd20);
        add_known(CMD_RETARGET, 5'd0,  16'h0000, 16'sh7FFF, 1'b1, '0, 16'sd0, 5'd0, 5'd0);
        add_reg  (CFG_FADE_SPEED, 16'h0000);
        add_beat (CMD_TICK,     5'd0,  16'h0001, 16'shFFFF);
        add_known(CMD_TICK,     5'd0,  16'hFFFF, 16'sh0000, 1'b0, PHASE_ONE, 16'sd0, 5'd0, 5'd0);
        add_reg  (CFG_FADE_SPEED, 16'hFFFF);
        add_reg  (CFG_START_LEVEL, 16'd31);
        add_known(CMD_RETARGET, 5'd0,  16'h0000, 16'sh1234, 1'b1, '0, 16'sd0, 5'd31, 5'd0);
        add_known(CMD_RETARGET, 5'd5,  16'h0000, 16'sh0200, 1'b1, '0, 16'sd0, 5'd31, 5'd5);
        add_beat (CMD_TICK,     5'd0,  16'h0001, 16'sh0200);
        add_known(CMD_TICK,     5'd0,  16'hFFFF, 16'sh0200, 1'b0, PHASE_ONE, 16'sd0, 5'd5, 5'd5);
        add_reg  (CFG_FADE_SPEED, 16'h0001);
        add_reg  (CFG_START_LEVEL, 16'd0);
        add_beat (CMD_RETARGET, 5'd31, 16'h0000, 16'sh4000);
        add_beat (CMD_TICK,     5'd0,  16'hFFFF, 16'sh4000);
        add_beat (CMD_TICK,     5'd0,  16'h00FF, 16'sh4000);
        add_beat (CMD_RETARGET, 5'd31, 16'h1234, 16'sh4000);
        add_reg  (CFG_FADE_SPEED, SPEED_DEFAULT);

        send_idle_pct  = 13;
        recv_stall_pct = 82;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_REG) begin
                drain_fades();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end else begin
                send_beat(dir_rows[k].cmd, dir_rows[k].lvl, dir_rows[k].dt, dir_rows[k].cd,
                          dir_rows[k].known, dir_rows[k].want);
            end
        end

        // Random: three idling phases, retuned between runs of beats
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 13 : (ph == 1) ? 82 : 0;
            recv_stall_pct = (ph == 0) ? 82 : (ph == 1) ? 13 : 0;
            for (int n = 0; n < RAND_ITEMS; n++) begin
                if (n % 50 == 49) begin
                    drain_fades();
                    if ($urandom_range(2) != 0) write_reg(CFG_FADE_SPEED, pick_speed());
                    if ($urandom_range(2) == 0)
                        write_reg(CFG_START_LEVEL,
                                  16'($urandom_range(0, (1 << LEVEL_BITS) - 1)));
                end
                cmd = ($urandom_range(99) < 30) ? CMD_RETARGET : CMD_TICK;
                send_beat(cmd, pick_level(), pick_dt(), pick_cd(), 1'b0, none);
            end
        end

        // Finish: wait out every result and the pipeline tail
        drain_fades();
        repeat (20) @(posedge i_clk);
        $display("summary: %0d ticks and %0d retargets sent, %0d register writes",
                 n_ticks, n_retargets, n_reg_writes);
        $display("summary: %0d results scored over three idling phases, %0d mismatches",
                 n_checked, n_mismatch);
        if (n_mismatch == 0 && pending_fades.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
